[rtl/pse_pkg.sv]
package pse_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_W    = 9;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 8;
	localparam int CLASS_W    = 2;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd42;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd42;
	localparam int MIN_DIM    = 3;
	localparam int MAX_HEIGHT = 4096;

	typedef logic [CLASS_W-1:0] class_t;

	// result beat, lowest field in the lowest bits
	typedef struct packed {
		logic [5:0]       pad;
		logic             edge_down_left;
		logic             edge_down;
		logic             edge_down_right;
		logic             edge_right;
		class_t           vertex_class;
		logic [COL_W-1:0] vertex_col;
		logic [ROW_W-1:0] vertex_row;
	} result_t;

	function automatic logic same_nonzero(class_t a, class_t b);
		return (a != '0) && (a == b);
	endfunction

endpackage

[rtl/pixel_similarity_edges.sv]
// Pixel similarity edges: 8-neighbour similarity flags over a padded class bitmap.
//
// s_axis carries one pixel class per beat in raster order. For each interior
// pixel (r,c) one beat leaves on m_axis once pixel (r+1,c+1) has arrived: row,
// column, class and the right, down-right, down and down-left equality flags
// (all clear for background). Border pixels give no beat.
// cfg writes image_width (index 0) or image_height (index 1); cfg_ready is
// always high. Writes belong between frames or while the block is idle.
// Throughput: one pixel per cycle while m_axis is not stalled. Each pixel reads
// one line-buffer entry and writes another in the same cycle; the buffer is a single
// memory with one write and one registered read port, and the up-left pixel is the
// previous read kept in a register, so no forwarding is needed.
// The memory is read and the read stage loads at the accepting edge of pixel
// (r+1,c+1); the output register loads when the read stage advances.
// Reset clears the position counters, the pipeline valids and the recent
// pixels, and loads 42 into both size registers. The line buffer is not
// cleared; every entry is written one row before it is read.
// When m_axis stalls, a pixel that gives no result still passes; one that
// does waits in the read stage and s_axis_tready drops until the output frees.
module pixel_similarity_edges
	import pse_pkg::*;
#(
	parameter int MAX_WIDTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] pixel_class
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [11:0] vertex_row, [19:12] vertex_col, [21:20] vertex_class, [22] edge_right,
	// [23] edge_down_right, [24] edge_down, [25] edge_down_left
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = AW + 1;

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [WW-1:0]       eff_w;
	logic [HEIGHT_W-1:0] eff_h;

	logic [AW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;
	class_t              recent0_q, recent1_q;

	logic                in_accept;
	class_t              px;
	logic                wrap_pre;
	logic [HEIGHT_W-1:0] row_pre;
	logic [ROW_W-1:0]    cur_r;
	logic [AW-1:0]       cur_c;
	logic [WW-1:0]       col_inc;
	logic [HEIGHT_W-1:0] row_inc;
	logic [AW-1:0]       next_col;
	logic [ROW_W-1:0]    next_row;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       col_m1;
	logic                emit;

	class_t              row_store [MAX_WIDTH];
	class_t              rd_q;
	class_t              up_prev_q;

	logic                valid_s1, emit_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [COL_W-1:0]    col_s1;
	class_t              px_s1, rec0_s1, rec1_s1;
	logic                advance_s1;

	logic                out_valid_q;
	result_t             out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(image_width_q) < MIN_DIM)
			eff_w = WW'(MIN_DIM);
		else if (32'(image_width_q) > MAX_WIDTH)
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = WW'(image_width_q);

		if (32'(image_height_q) < MIN_DIM)
			eff_h = HEIGHT_W'(MIN_DIM);
		else if (32'(image_height_q) > MAX_HEIGHT)
			eff_h = HEIGHT_W'(MAX_HEIGHT);
		else
			eff_h = image_height_q;
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign px        = s_axis_tdata[CLASS_W-1:0];

	// position of this pixel; a size change may leave the counters past the frame
	always_comb begin
		wrap_pre = {1'b0, col_q} >= eff_w;
		row_pre  = wrap_pre ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
		cur_r    = (row_pre >= eff_h) ? '0 : row_pre[ROW_W-1:0];
		cur_c    = wrap_pre ? '0 : col_q;

		col_inc  = {1'b0, cur_c} + 1'b1;
		row_inc  = {1'b0, cur_r} + 1'b1;
		if (col_inc >= eff_w) begin
			next_col = '0;
			next_row = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
		end else begin
			next_col = col_inc[AW-1:0];
			next_row = cur_r;
		end

		// the previous pixel lands one column back; at column 0 it closes the last row
		col_m1  = cur_c - 1'b1;
		wr_addr = (cur_c == '0) ? AW'(eff_w - 1'b1) : col_m1;
		emit    = (cur_r >= ROW_W'(2)) && (cur_c >= AW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			recent0_q <= '0;
			recent1_q <= '0;
		end else if (in_accept) begin
			col_q     <= next_col;
			row_q     <= next_row;
			recent0_q <= px;
			recent1_q <= recent0_q;
		end
	end

	// line buffer: write and read addresses never meet in one cycle (width >= 3)
	always_ff @(posedge clk) begin
		if (in_accept) begin
			row_store[wr_addr] <= recent0_q;
			rd_q               <= row_store[cur_c];
		end
	end

	assign advance_s1    = valid_s1 && (!emit_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (advance_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			emit_s1 <= emit;
			row_s1  <= cur_r - 1'b1;
			col_s1  <= COL_W'(col_m1);
			px_s1   <= px;
			rec0_s1 <= recent0_q;
			rec1_s1 <= recent1_q;
		end
		// the above entry of one pixel is the above-left entry of the next
		if (advance_s1)
			up_prev_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance_s1 && emit_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit_s1) begin
			out_q.pad             <= '0;
			out_q.vertex_row      <= row_s1;
			out_q.vertex_col      <= col_s1;
			out_q.vertex_class    <= up_prev_q;
			out_q.edge_right      <= same_nonzero(up_prev_q, rd_q);
			out_q.edge_down_right <= same_nonzero(up_prev_q, px_s1);
			out_q.edge_down       <= same_nonzero(up_prev_q, rec0_s1);
			out_q.edge_down_left  <= same_nonzero(up_prev_q, rec1_s1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

[rtl/pse_checker.sv]
module pse_checker
	import pse_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	result_t res;
	assign res = m_axis_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_bg_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.vertex_class == '0) |->
			!res.edge_right && !res.edge_down_right && !res.edge_down && !res.edge_down_left)
		else $error("background pixel reported with an edge");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result beat without a pixel two cycles earlier");

endmodule

bind pixel_similarity_edges pse_checker u_pse_checker (.*);

[verif/similarity_edge_checker.sv]
`timescale 1ns / 1ps

module similarity_edge_checker
	import pse_pkg::*;
#(
	parameter int MAX_W = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] pixel_class
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [11:0] vertex_row, [19:12] vertex_col, [21:20] vertex_class, [22] edge_right,
	// [23] edge_down_right, [24] edge_down, [25] edge_down_left
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     outstanding,
	output int                     pixels_to_home,
	output int                     frame_width
);

	localparam int RING = 1024;

	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	class_t              line_buf [MAX_W];
	class_t              last_px;
	class_t              prev_px;
	int                  row_pos;
	int                  col_pos;
	result_t             awaited_edges [RING];
	int                  head;
	int                  tail;
	int                  fails;

	function automatic int bound(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int eff_width();
		return bound(int'(width_reg), MIN_DIM, MAX_W);
	endfunction

	function automatic int eff_height();
		return bound(int'(height_reg), MIN_DIM, MAX_HEIGHT);
	endfunction

	function automatic logic same_kind(class_t a, class_t b);
		return (a != '0) && (a == b);
	endfunction

	// beats still needed to come back to row 0, column 0
	function automatic int left_in_frame();
		int w, h, r, c;
		w = eff_width();
		h = eff_height();
		r = row_pos;
		c = col_pos;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
		if (r == 0 && c == 0)
			return 0;
		return (h - r) * w - c;
	endfunction

	task automatic predict_edges(input class_t px);
		int w, h, r, c;
		class_t up_left, up;
		result_t e;
		w = eff_width();
		h = eff_height();
		// a size change may leave the counters past the frame
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		if (c == 0) begin
			line_buf[w - 1] = last_px;
		end else begin
			up_left = line_buf[c - 1];
			up = (c < MAX_W) ? line_buf[c] : '0;
			if (r >= 2 && c >= 2) begin
				e = '0;
				e.vertex_row = ROW_W'(r - 1);
				e.vertex_col = COL_W'(c - 1);
				e.vertex_class = up_left;
				e.edge_right = same_kind(up_left, up);
				e.edge_down_right = same_kind(up_left, px);
				e.edge_down = same_kind(up_left, last_px);
				e.edge_down_left = same_kind(up_left, prev_px);
				awaited_edges[tail % RING] = e;
				tail++;
			end
			line_buf[c - 1] = last_px;
		end
		prev_px = last_px;
		last_px = px;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic compare(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	task automatic check_beat(input result_t got);
		result_t want;
		if (head == tail) begin
			$display("%0t: unexpected beat, expected none, got row %0d col %0d class %0d flags %b",
				$time, got.vertex_row, got.vertex_col, got.vertex_class,
				{got.edge_down_left, got.edge_down, got.edge_down_right, got.edge_right});
			fails++;
		end else begin
			want = awaited_edges[head % RING];
			head++;
			compare("vertex_row", 16'(want.vertex_row), 16'(got.vertex_row));
			compare("vertex_col", 16'(want.vertex_col), 16'(got.vertex_col));
			compare("vertex_class", 16'(want.vertex_class), 16'(got.vertex_class));
			compare("edge_right", 16'(want.edge_right), 16'(got.edge_right));
			compare("edge_down_right", 16'(want.edge_down_right), 16'(got.edge_down_right));
			compare("edge_down", 16'(want.edge_down), 16'(got.edge_down));
			compare("edge_down_left", 16'(want.edge_down_left), 16'(got.edge_down_left));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			for (int i = 0; i < MAX_W; i++)
				line_buf[i] = '0;
			last_px = '0;
			prev_px = '0;
			row_pos = 0;
			col_pos = 0;
			head = 0;
			tail = 0;
			fails = 0;
		end else begin
			// a result leaves only after its pixel has been registered, so pop before push
			if (m_axis_tvalid && m_axis_tready)
				check_beat(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				predict_edges(s_axis_tdata[CLASS_W-1:0]);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data[WIDTH_W-1:0];
				else if (cfg_index == REG_HEIGHT)
					height_reg = cfg_data[HEIGHT_W-1:0];
			end
		end
		errors <= fails;
		outstanding <= tail - head;
		pixels_to_home <= left_in_frame();
		frame_width <= eff_width();
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import pse_pkg::*;

	localparam int MAX_W       = 256;
	localparam int RUN_ITEMS   = 1550;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE      = 4;

	localparam class_t CL_BG    = 2'd0;
	localparam class_t CL_HALF  = 2'd1;
	localparam class_t CL_FULL  = 2'd2;
	localparam class_t CL_SPARE = 2'd3;

	// 8 rows of 3 pixels, row 0 in the low bits, column 0 lowest within a row
	localparam logic [47:0] DEMO_PIXELS = {
		CL_BG,    CL_BG,    CL_BG,
		CL_SPARE, CL_BG,    CL_SPARE,
		CL_FULL,  CL_SPARE, CL_FULL,
		CL_SPARE, CL_FULL,  CL_SPARE,
		CL_FULL,  CL_FULL,  CL_FULL,
		CL_HALF,  CL_HALF,  CL_HALF,
		CL_HALF,  CL_HALF,  CL_HALF,
		CL_HALF,  CL_HALF,  CL_HALF
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int     errors;
	int     outstanding;
	int     pixels_to_home;
	int     frame_width;
	int     cycles = 0;
	int     random_items = 0;
	bit     calm = 1'b0;
	class_t last_sent = '0;

	pixel_similarity_edges #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	similarity_edge_checker #(
		.MAX_W(MAX_W)
	) edge_watch (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding),
		.pixels_to_home(pixels_to_home),
		.frame_width(frame_width)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("pixel_similarity_edges: mismatch");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return CFG_DATA_W'($urandom_range(MIN_DIM, 16));
		if (roll < 72)
			return CFG_DATA_W'($urandom_range(17, 64));
		if (roll < 80)
			return CFG_DATA_W'(MAX_W);
		if (roll < 86)
			return CFG_DATA_W'($urandom_range(MAX_W + 1, 511));
		if (roll < 93)
			return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
		return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return CFG_DATA_W'($urandom_range(MIN_DIM, 6));
		if (roll < 76)
			return CFG_DATA_W'($urandom_range(7, 40));
		if (roll < 84)
			return CFG_DATA_W'(MAX_HEIGHT);
		if (roll < 90)
			return CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, (1 << CFG_DATA_W) - 1));
		return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
	endfunction

	// receiver: ready bursts broken by stalls unless calm is set
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!calm) begin
				m_axis_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// valid stays up across back-to-back beats, drops only for a gap
	task automatic send_pixel(input class_t px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - CLASS_W){1'b0}}, px};
		last_sent = px;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// runs of equal classes so that edges show up often
	task automatic send_run(input int n);
		class_t px;
		for (int k = 0; k < n; k++) begin
			px = $urandom_range(0, 1) ? last_sent : class_t'($urandom_range(0, 3));
			send_pixel(px);
			random_items++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// finish the frame; a tall one is cut to three rows first
	task automatic close_frame();
		if (pixels_to_home > 800) begin
			write_reg(REG_HEIGHT, CFG_DATA_W'(MIN_DIM));
			cfg_valid <= 1'b0;
			settle();
		end
		send_run(pixels_to_home);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both sizes out of range: 3 wide, 4096 tall
		write_reg(REG_WIDTH, '0);
		write_reg(REG_HEIGHT, '1);
		cfg_valid <= 1'b0;
		for (int k = 0; k < 24; k++)
			send_pixel(DEMO_PIXELS[2*k +: 2]);
		settle();

		// height below the current row: the next beat wraps to row 0
		write_reg(REG_HEIGHT, CFG_DATA_W'(5));
		cfg_valid <= 1'b0;
		send_run(7);
		settle();
		close_frame();
		settle();

		write_reg(REG_WIDTH, CFG_DATA_W'(MAX_W));
		write_reg(REG_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
		cfg_valid <= 1'b0;
		send_run($urandom_range(520, 700));

		while (random_items < RUN_ITEMS) begin
			settle();
			calm = ($urandom_range(0, 4) == 0);
			if (pixels_to_home == 0) begin
				// widening is only safe at the top of a frame
				if ($urandom_range(0, 2) != 0) begin
					write_reg(REG_WIDTH, pick_width());
					write_reg(REG_HEIGHT, pick_height());
					cfg_valid <= 1'b0;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: close_frame();
					1: begin
						write_reg(REG_HEIGHT, pick_height());
						cfg_valid <= 1'b0;
					end
					2: begin
						write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, frame_width)));
						cfg_valid <= 1'b0;
					end
					default: ;
				endcase
			end
			send_run(($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 48));
		end

		settle();
		calm = 1'b1;
		repeat (2 * SETTLE) @(posedge clk);
		if (errors == 0)
			$display("pixel_similarity_edges: match");
		else
			$display("pixel_similarity_edges: mismatch");
		$finish;
	end

endmodule
